>>> src/cma_pkg.sv
// Shared constants, state encoding and controller/datapath bundles for the moving average core.
package cma_pkg;

	localparam int MAX_HALF_WIDTH = 63;
	localparam int HW_W = 6;
	localparam int SAMPLE_W = 8;
	localparam int SUM_W = 15;
	localparam int CNT_W = 7;
	localparam int ADDR_W = 7;
	localparam int RAM_DEPTH = 1 << ADDR_W;
	localparam int DIV_STEPS = SUM_W;
	localparam int DSTEP_W = 4;
	localparam logic [CNT_W-1:0] SEEN_MAX = 7'd127;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CHECK,
		ST_DIV,
		ST_FLUSH,
		ST_TRIM,
		ST_TRIM_RD
	} cma_state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic push;
		logic start_div;
		logic flush_flag;
		logic emit;
		logic flush_step;
		logic trim_rd;
		logic trim_sub;
		logic clear;
	} cma_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
		logic emit_due;
		logic r_zero;
		logic trim_more;
		logic div_busy;
		logic out_free;
	} cma_status_t;

endpackage

>>> src/cma_ifs.sv
// Channel interfaces: sample input, result output and configuration write.
interface cma_sample_if import cma_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_in;
	logic                last_in;
	modport source(output valid, sample_in, last_in, input ready);
	modport sink(input valid, sample_in, last_in, output ready);
endinterface

interface cma_result_if import cma_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] mean_out;
	logic                last_out;
	modport source(output valid, mean_out, last_out, input ready);
	modport sink(input valid, mean_out, last_out, output ready);
endinterface

interface cma_cfg_if import cma_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [HW_W-1:0] half_width;
	modport source(output valid, half_width, input ready);
	modport sink(input valid, half_width, output ready);
endinterface

>>> src/cma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/cma_datapath.sv
// Datapath: sample ring, running sum, counters, serial divider and output register.
module cma_datapath import cma_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [HW_W-1:0]     cfg_half_width,
	input  logic [SAMPLE_W-1:0] sample_in,
	input  logic                last_in,
	input  cma_cmd_t            cmd,
	output cma_status_t         status,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] mean_out,
	output logic                last_out
);

	logic [HW_W-1:0]     hw_q;
	logic [HW_W-1:0]     h_c;
	logic [CNT_W-1:0]    span_c;
	logic [SAMPLE_W-1:0] x_q;
	logic                last_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    seen_q;
	logic [CNT_W-1:0]    seen_inc_c;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    want_q;
	logic [CNT_W-1:0]    want_c;
	logic [HW_W-1:0]     r_q;
	logic [ADDR_W-1:0]   wp_q;
	logic [ADDR_W-1:0]   raddr_c;
	logic [SAMPLE_W-1:0] rd_data;
	logic [SAMPLE_W-1:0] sub_c;
	logic                div_busy_q;
	logic [DSTEP_W-1:0]  step_q;
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W:0]      trial_c;
	logic [CNT_W:0]      diff_c;
	logic                ge_c;
	logic                flag_q;
	logic                ovalid_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic                olast_q;
	logic                out_free_c;

	// effective half width and window span
	assign h_c = (hw_q > HW_W'(MAX_HALF_WIDTH)) ? HW_W'(MAX_HALF_WIDTH) : hw_q;
	assign span_c = {h_c, 1'b1};
	assign seen_inc_c = (seen_q < SEEN_MAX) ? seen_q + CNT_W'(1) : seen_q;
	// oldest window sample drops out only once the window is full
	assign sub_c = (seen_q >= span_c) ? rd_data : '0;
	assign want_c = (seen_q < CNT_W'(r_q) + CNT_W'(h_c)) ? seen_q
		: CNT_W'(r_q) + CNT_W'(h_c);

	// ring read: oldest sample of the window, or the next one to trim
	assign raddr_c = cmd.trim_rd ? wp_q - ADDR_W'(cnt_q) : wp_q - ADDR_W'(span_c);

	cma_ram #(.WIDTH(SAMPLE_W), .DEPTH(RAM_DEPTH)) u_ring (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(wp_q),
		.wdata(x_q),
		.raddr(raddr_c),
		.rdata(rd_data)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= HW_W'(1);
		end else if (cfg_valid) begin
			hw_q <= cfg_half_width;
		end
	end

	// input beat capture
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q <= sample_in;
			last_q <= last_in;
		end
	end

	// window state: running sum, counters, write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			seen_q <= '0;
			cnt_q <= '0;
			want_q <= '0;
			r_q <= '0;
			wp_q <= '0;
		end else begin
			if (cmd.push) begin
				sum_q <= sum_q - SUM_W'(sub_c) + SUM_W'(x_q);
				seen_q <= seen_inc_c;
				cnt_q <= (seen_inc_c < span_c) ? seen_inc_c : span_c;
				r_q <= (seen_inc_c < CNT_W'(h_c)) ? seen_inc_c[HW_W-1:0] : h_c;
				wp_q <= wp_q + ADDR_W'(1);
			end
			if (cmd.flush_step) begin
				r_q <= r_q - HW_W'(1);
				want_q <= want_c;
			end
			if (cmd.trim_rd) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.trim_sub) begin
				sum_q <= sum_q - SUM_W'(rd_data);
			end
			if (cmd.clear) begin
				sum_q <= '0;
				seen_q <= '0;
			end
		end
	end

	// restoring divider, one quotient bit a cycle
	assign trial_c = {rem_q, quo_q[SUM_W-1]};
	assign ge_c = trial_c >= {1'b0, cnt_q};
	assign diff_c = trial_c - {1'b0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			step_q <= '0;
		end else if (cmd.start_div) begin
			div_busy_q <= 1'b1;
			step_q <= '0;
		end else if (div_busy_q) begin
			step_q <= step_q + DSTEP_W'(1);
			if (step_q == DSTEP_W'(DIV_STEPS - 1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			quo_q <= sum_q;
			rem_q <= '0;
			flag_q <= cmd.flush_flag ? (r_q == '0) : (last_q && (h_c == '0));
		end else if (div_busy_q) begin
			rem_q <= ge_c ? diff_c[CNT_W-1:0] : trial_c[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge_c};
		end
	end

	// output register, mean saturates at full scale
	assign out_free_c = !ovalid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			mean_q <= (|quo_q[SUM_W-1:SAMPLE_W]) ? '1 : quo_q[SAMPLE_W-1:0];
			olast_q <= flag_q;
		end
	end

	assign out_valid = ovalid_q;
	assign mean_out = mean_q;
	assign last_out = olast_q;

	always_comb begin
		status.last = last_q;
		status.emit_due = seen_q > CNT_W'(h_c);
		status.r_zero = (r_q == '0);
		status.trim_more = cnt_q > want_q;
		status.div_busy = div_busy_q;
		status.out_free = out_free_c;
	end

	// a result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!ovalid_q || out_ready))
		else $error("result register overwritten");

	// a result is loaded only after the divider has finished
	a_emit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !div_busy_q)
		else $error("result taken from busy divider");

	// every division has a nonzero window count
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |-> (cnt_q != '0))
		else $error("division by zero count");

endmodule

>>> src/cma_ctrl.sv
// Controller state machine sequencing update, divide, emit and end-of-stream flush.
module cma_ctrl import cma_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cma_status_t status,
	output cma_cmd_t    cmd
);

	cma_state_t state_q;
	cma_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = status.emit_due ? ST_DIV : ST_FLUSH;
			end
			ST_DIV: begin
				if (!status.div_busy && status.out_free) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!status.last || status.r_zero) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				state_d = status.trim_more ? ST_TRIM_RD : ST_DIV;
			end
			ST_TRIM_RD: state_d = ST_TRIM;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_LOAD: cmd.push = 1'b1;
			ST_CHECK: begin
				cmd.start_div = status.emit_due;
			end
			ST_DIV: begin
				cmd.emit = !status.div_busy && status.out_free;
			end
			ST_FLUSH: begin
				cmd.clear = status.last && status.r_zero;
				cmd.flush_step = status.last && !status.r_zero;
			end
			ST_TRIM: begin
				cmd.trim_rd = status.trim_more;
				cmd.start_div = !status.trim_more;
				cmd.flush_flag = !status.trim_more;
			end
			ST_TRIM_RD: cmd.trim_sub = 1'b1;
			default: cmd = '0;
		endcase
	end

	// trimming happens only while flushing a stream that has ended
	a_trim_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRIM) |-> status.last)
		else $error("trim outside end-of-stream flush");

endmodule

>>> src/centered_moving_average_core.sv
// Top level of the centered moving average core: channels, controller and datapath.
//
//  channel    | dir | beat contents           | handshake
//  -----------+-----+-------------------------+-----------
//  cfg_ch     | in  | half_width (6b)         | valid/ready, ready always high
//  sample_ch  | in  | sample_in (8b), last_in | valid/ready
//  result_ch  | out | mean_out (8b), last_out | valid/ready, registered
//
// An input beat that yields a mean is taken in idle, pushed into the ring and the
// running sum, divided in the bit-serial divider and emitted, and the core returns
// to idle. An end-of-stream beat adds per flushed output a flush step, a read and
// subtract per trimmed sample, then another divide. Reset clears all control
// state; the ring memory needs no clearing. A stalled result register holds the
// divider in place; the next input beat is accepted while a result still waits.
module centered_moving_average_core import cma_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	cma_cfg_if.sink      cfg_ch,
	cma_sample_if.sink   sample_ch,
	cma_result_if.source result_ch
);

	cma_cmd_t    cmd;
	cma_status_t status;

	assign cfg_ch.ready = 1'b1;

	cma_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(sample_ch.valid),
		.in_ready(sample_ch.ready),
		.status  (status),
		.cmd     (cmd)
	);

	cma_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_ch.valid),
		.cfg_half_width(cfg_ch.half_width),
		.sample_in     (sample_ch.sample_in),
		.last_in       (sample_ch.last_in),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (result_ch.valid),
		.out_ready     (result_ch.ready),
		.mean_out      (result_ch.mean_out),
		.last_out      (result_ch.last_out)
	);

endmodule

>>> tb/sv/centered_moving_average_core_tb.sv
// Self-checking testbench for the centered moving average core: random streams against a predictor.
module centered_moving_average_core_tb;
	import cma_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH = 2 * MAX_HALF_WIDTH + 1;
	localparam int RANDOM_ITEMS = 440;
	localparam int PHASE_ITEMS = 36;
	localparam int LONG_STREAM = 140;
	localparam int SETTLE_CYCLES = 48;
	localparam int END_CYCLES = 200;
	localparam int IDLE_LIMIT = 4000;
	localparam int IDLE_PCT = 23;
	localparam int HOLD_AT = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int SEND_QUIET_LO = 280;
	localparam int SEND_QUIET_HI = 360;
	localparam int TAKE_QUIET_LO = 260;
	localparam int TAKE_QUIET_HI = 340;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} sample_beat_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean;
		logic                last;
	} mean_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	cma_cfg_if    cfg_ch();
	cma_sample_if sample_ch();
	cma_result_if result_ch();

	centered_moving_average_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_ch    (cfg_ch),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [HW_W-1:0]     width_model = HW_W'(1);
	logic [SAMPLE_W-1:0] ring_model [RING_DEPTH];
	logic [SUM_W-1:0]    sum_model = '0;
	int unsigned         seen_model = 0;

	sample_beat_t sample_queue[$];
	mean_beat_t   mean_queue[$];
	sample_beat_t cur_beat;
	bit           beat_held = 1'b0;
	int unsigned  beats_sent = 0;
	int unsigned  results_taken = 0;
	int unsigned  mismatches = 0;
	int unsigned  hold_left = 0;
	bit           hold_done = 1'b0;

	function automatic bit idle_now(input int unsigned count, input int unsigned lo,
			input int unsigned hi);
		if (count >= lo && count < hi)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	// queue one mean over the current sum
	function automatic void queue_mean(input int unsigned count, input bit flag);
		int unsigned q;
		mean_beat_t  m;
		q = int'(sum_model) / count;
		if (q > 255)
			q = 255;
		m.mean = q[SAMPLE_W-1:0];
		m.last = flag;
		mean_queue.push_back(m);
	endfunction

	// running-sum window update, then the means this beat releases
	function automatic void predict_means(input sample_beat_t beat);
		int unsigned h, span, cnt, r, want, d;
		h = (width_model > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : width_model;
		span = 2 * h + 1;
		cnt = (seen_model < span) ? seen_model : span;
		if (cnt == span)
			sum_model = sum_model - SUM_W'(ring_model[span-1]);
		for (d = RING_DEPTH - 1; d > 0; d--)
			ring_model[d] = ring_model[d-1];
		ring_model[0] = beat.sample;
		sum_model = sum_model + SUM_W'(beat.sample);
		if (seen_model < SEEN_MAX)
			seen_model++;
		cnt = (seen_model < span) ? seen_model : span;
		if (seen_model > h)
			queue_mean(cnt, beat.last && h == 0);
		// end of stream: shrink the window from the old side for each pending mean
		if (beat.last) begin
			r = (seen_model < h) ? seen_model : h;
			while (r > 0) begin
				r--;
				want = (seen_model < r + 1 + h) ? seen_model : r + 1 + h;
				while (cnt > want) begin
					cnt--;
					sum_model = sum_model - SUM_W'(ring_model[cnt]);
				end
				queue_mean(want, r == 0);
			end
			sum_model = '0;
			seen_model = 0;
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(255));
		endcase
	endfunction

	function automatic void push_sample(input logic [SAMPLE_W-1:0] s, input bit l);
		sample_beat_t b;
		b.sample = s;
		b.last = l;
		sample_queue.push_back(b);
	endfunction

	// sample driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				predict_means(cur_beat);
				beats_sent++;
				beat_held = 1'b0;
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (sample_queue.size() != 0 &&
						!idle_now(beats_sent, SEND_QUIET_LO, SEND_QUIET_HI)) begin
					cur_beat = sample_queue.pop_front();
					beat_held = 1'b1;
					sample_ch.valid <= 1'b1;
					sample_ch.sample_in <= cur_beat.sample;
					sample_ch.last_in <= cur_beat.last;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end else begin
			sample_ch.valid <= 1'b0;
			sample_ch.sample_in <= '0;
			sample_ch.last_in <= 1'b0;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		mean_beat_t m;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				results_taken++;
				if (mean_queue.size() == 0) begin
					$error("unexpected result beat: mean_out %0d, last_out %0d",
						result_ch.mean_out, result_ch.last_out);
					mismatches++;
				end else begin
					m = mean_queue.pop_front();
					check_field("mean_out", m.mean, result_ch.mean_out);
					check_field("last_out", m.last, result_ch.last_out);
				end
			end
			// one long hold-off while the sender still has beats queued
			if (!hold_done && results_taken >= HOLD_AT && sample_queue.size() >= 8) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !idle_now(results_taken, TAKE_QUIET_LO, TAKE_QUIET_HI);
			end
		end else begin
			result_ch.ready <= 1'b0;
		end
	end

	// watchdog: cycles with no beat on any channel
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (sample_ch.valid && sample_ch.ready) ||
					(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic wait_drained();
		while (sample_queue.size() != 0 || beat_held || mean_queue.size() != 0)
			@(posedge clk);
	endtask

	// width writes only with the core idle
	task automatic set_half_width(input int unsigned w);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.half_width <= HW_W'(w);
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		width_model = HW_W'(w);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned plan [12];
		int unsigned phase, n, len, i, w, random_sent;
		bit cut;
		plan = '{63, 0, 63, 1, 2, 3, 7, 15, 31, 0, 4, 63};
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.half_width = '0;
		for (i = 0; i < RING_DEPTH; i++)
			ring_model[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset width of one, sample extremes
		push_sample(8'd0, 1'b0);
		push_sample(8'd255, 1'b0);
		push_sample(8'd128, 1'b0);
		push_sample(8'd1, 1'b0);
		push_sample(8'd255, 1'b1);
		// one-sample stream
		push_sample(8'd77, 1'b1);
		// zero width: samples pass straight through
		set_half_width(0);
		push_sample(8'd255, 1'b0);
		push_sample(8'd0, 1'b0);
		push_sample(8'd170, 1'b1);
		// widest window, stream shorter than half the window
		set_half_width(MAX_HALF_WIDTH);
		for (i = 0; i < 5; i++)
			push_sample(rand_sample(), i == 4);
		// width shrunk mid-stream: oversized sum saturates the mean
		set_half_width(5);
		repeat (8) push_sample(8'd255, 1'b0);
		set_half_width(2);
		push_sample(8'd255, 1'b0);
		push_sample(8'd0, 1'b0);
		push_sample(8'd255, 1'b1);

		// random phases, each starting from a drained core
		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			w = (phase < 12) ? plan[phase] : $urandom_range(MAX_HALF_WIDTH);
			set_half_width(w);
			n = 0;
			if (phase == 2) begin
				// long stream: seen count saturates
				for (i = 0; i < LONG_STREAM; i++)
					push_sample(rand_sample(), i == LONG_STREAM - 1);
				n = LONG_STREAM;
			end else begin
				while (n < PHASE_ITEMS) begin
					len = ($urandom_range(4) == 0) ? $urandom_range(13, 48)
						: $urandom_range(1, 12);
					// sometimes leave the stream open across the next width change
					cut = (n + len >= PHASE_ITEMS) && ($urandom_range(3) == 0);
					for (i = 0; i < len; i++)
						push_sample(rand_sample(), (i == len - 1) && !cut);
					n += len;
				end
			end
			random_sent += n;
			phase++;
		end

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (mean_queue.size() != 0) begin
			$error("%0d expected result beats never arrived", mean_queue.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
src/cma_pkg.sv
src/cma_ifs.sv
src/cma_ram.sv
src/cma_datapath.sv
src/cma_ctrl.sv
src/centered_moving_average_core.sv
tb/sv/centered_moving_average_core_tb.sv
